@@ rtl/ipv6_dotp_pkg.sv @@
// Shared types and constants for the IPv6 destination options TLV parser.
// Depends on nothing; imported by ipv6_dest_option_tlv_parser_top.
`timescale 1ns / 1ps

package ipv6_dotp_pkg;

  // Parse phase codes.
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_TYPE   = 3'd2;
  localparam logic [2:0] PH_OPTLEN = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  // Verdict codes.
  localparam logic [1:0] VERDICT_ACCEPT    = 2'd0;
  localparam logic [1:0] VERDICT_DROP      = 2'd1;
  localparam logic [1:0] VERDICT_ICMP      = 2'd2;
  localparam logic [1:0] VERDICT_MALFORMED = 2'd3;

  // Unknown-option action codes, taken from type bits 7..6.
  localparam logic [1:0] ACT_SKIP      = 2'd0;
  localparam logic [1:0] ACT_DROP      = 2'd1;
  localparam logic [1:0] ACT_ICMP      = 2'd2;
  localparam logic [1:0] ACT_ICMP_UCST = 2'd3;

  // Option types with built-in handling.
  localparam logic [7:0] OPT_PAD1 = 8'd0;
  localparam logic [7:0] OPT_PADN = 8'd1;

  // One result item.
  typedef struct packed {
    logic [1:0]  verdict;
    logic [7:0]  next_header;
    logic [15:0] icmp_pointer;
  } result_t;

endpackage

@@ rtl/ipv6_dest_option_tlv_parser_top.sv @@
// Top level of the IPv6 destination options TLV parser.
// Depends on ipv6_dotp_pkg for phase, verdict and action codes and the result type.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_ready  data_byte, first_byte, header_offset, dst_multicast
// output    out        out_valid/out_ready  verdict, next_header, icmp_pointer
//
// The parse state is updated at the edge where an item is accepted; any result lands in the
// output register at that same edge, or in the skid register while the output is held.
// While the skid register is empty, one header byte per clock is accepted and sustained.
// A skid register behind the output register lets one more result be taken while the
// output is stalled; in_ready falls only while the skid register is occupied.
// Synchronous reset clears the parse phase and both result valid flags.

module ipv6_dest_option_tlv_parser_top
  import ipv6_dotp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic [15:0] header_offset,
  input  logic        dst_multicast,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  verdict,
  output logic [7:0]  next_header,
  output logic [15:0] icmp_pointer
);

  // Parse state.
  logic [2:0]  phase, phase_next;
  logic [7:0]  saved_next_header, saved_next_header_next;
  logic [10:0] bytes_left, bytes_left_next;
  logic [7:0]  option_skip_count, option_skip_count_next;
  logic [15:0] option_pointer, option_pointer_next;
  logic        multicast_flag, multicast_flag_next;

  // Result storage: output register plus one skid entry.
  result_t     out_item, skid_item, new_item;
  logic        skid_valid;
  logic        push;
  logic        accept;

  logic [1:0]  action;
  logic [10:0] bytes_dec;

  assign accept = in_valid && in_ready;
  assign in_ready = !skid_valid;

  assign action    = data_byte[7:6];
  assign bytes_dec = bytes_left - 11'd1;

  // Next-state logic for one accepted byte.
  always_comb begin
    phase_next             = phase;
    saved_next_header_next = saved_next_header;
    bytes_left_next        = bytes_left;
    option_skip_count_next = option_skip_count;
    option_pointer_next    = option_pointer;
    multicast_flag_next    = multicast_flag;
    push                   = 1'b0;
    new_item.verdict       = VERDICT_ACCEPT;
    new_item.next_header   = saved_next_header;
    new_item.icmp_pointer  = 16'd0;

    if (first_byte) begin
      // A first byte always opens a new header, abandoning any one in progress.
      saved_next_header_next = data_byte;
      multicast_flag_next    = dst_multicast;
      option_pointer_next    = header_offset + 16'd1;
      bytes_left_next        = 11'd0;
      option_skip_count_next = 8'd0;
      phase_next             = PH_LEN;
    end else begin
      unique case (phase) inside
        PH_LEN: begin
          option_pointer_next = option_pointer + 16'd1;
          // Header is (len + 1) * 8 bytes; two are already consumed.
          bytes_left_next     = {data_byte, 3'b110};
          phase_next          = PH_TYPE;
        end
        PH_TYPE, PH_OPTLEN, PH_SKIP: begin
          option_pointer_next = option_pointer + 16'd1;
          if (phase == PH_TYPE && data_byte != OPT_PAD1 && data_byte != OPT_PADN &&
              action != ACT_SKIP) begin
            // Unknown option whose action is not skip (drop or ICMP): report at once.
            push       = 1'b1;
            phase_next = PH_DONE;
            if (action == ACT_DROP || (action == ACT_ICMP_UCST && multicast_flag)) begin
              new_item.verdict = VERDICT_DROP;
            end else begin
              new_item.verdict      = VERDICT_ICMP;
              new_item.icmp_pointer = option_pointer;
            end
          end else begin
            if (phase == PH_TYPE) begin
              // Pad1 stays on an option boundary; others read a length next.
              if (data_byte != OPT_PAD1) begin
                phase_next = PH_OPTLEN;
              end
            end else if (phase == PH_OPTLEN) begin
              option_skip_count_next = data_byte;
              phase_next = (data_byte == 8'd0) ? PH_TYPE : PH_SKIP;
            end else begin
              option_skip_count_next = option_skip_count - 8'd1;
              if (option_skip_count == 8'd1) begin
                phase_next = PH_TYPE;
              end
            end
            bytes_left_next = bytes_dec;
            if (bytes_dec == 11'd0) begin
              // End of header: clean only when it ends on an option boundary.
              push       = 1'b1;
              new_item.verdict = (phase_next == PH_TYPE) ? VERDICT_ACCEPT
                                                         : VERDICT_MALFORMED;
              phase_next = PH_DONE;
            end
          end
        end
        default: begin
          // Idle, done and unused codes ignore stray bytes.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
    if (accept) begin
      saved_next_header <= saved_next_header_next;
      bytes_left        <= bytes_left_next;
      option_skip_count <= option_skip_count_next;
      option_pointer    <= option_pointer_next;
      multicast_flag    <= multicast_flag_next;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= accept && push;
      end else begin
        out_valid  <= accept && push;
      end
    end else if (accept && push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_item  <= skid_item;
        skid_item <= new_item;
      end else begin
        out_item  <= new_item;
      end
    end else if (accept && push && !skid_valid) begin
      skid_item <= new_item;
    end
  end

  assign verdict      = out_item.verdict;
  assign next_header  = out_item.next_header;
  assign icmp_pointer = out_item.icmp_pointer;

  // The skid entry is only ever filled behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without output valid");

  // Only an ICMP verdict carries a pointer.
  a_pointer_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict != VERDICT_ICMP) |-> (icmp_pointer == 16'd0))
    else $error("icmp_pointer set without ICMP verdict");

  // A first byte always leads to the length phase.
  a_first_to_len: assert property (@(posedge clk) disable iff (rst)
    (accept && first_byte) |=> (phase == PH_LEN))
    else $error("first byte did not start a header");

  // Every result closes the header.
  a_result_done: assert property (@(posedge clk) disable iff (rst)
    (accept && push) |=> (phase == PH_DONE && out_valid))
    else $error("result given without closing the header");

endmodule
